FILE: design/hmt_pkg.sv
// Package for the hyperbox micro-cluster table: widths, item kinds, status codes,
// register indexes and the types shared between the cell, divider and top level.
// No dependencies.
`default_nettype none
package hmt_pkg;
    localparam int MaxClusters = 16;
    localparam int Features    = 4;
    localparam int SlotW       = 4;
    localparam int CountW      = 5;
    localparam int FeatW       = 16;
    localparam int DistW       = 18;
    localparam int NCntW       = 16;
    localparam int DateW       = 32;

    typedef enum logic [1:0] {
        KIND_SEARCH = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_ABSORB = 2'd2,
        KIND_AGE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_UNUSED = 2'd3
    } status_t;

    localparam logic [2:0] REG_BOX0    = 3'd0;
    localparam logic [2:0] REG_BOX1    = 3'd1;
    localparam logic [2:0] REG_BOX2    = 3'd2;
    localparam logic [2:0] REG_BOX3    = 3'd3;
    localparam logic [2:0] REG_AGE_THR = 3'd4;
    localparam logic [2:0] REG_AGE_PEN = 3'd5;

    typedef logic signed [FeatW-1:0] feat_t;

    // Beat that walks the chain, one cell further each cycle; only one item walks the chain at a time
    typedef struct packed {
        logic                    valid;
        logic [1:0]              kind;
        feat_t [Features-1:0]    feat;
        logic [DateW-1:0]        date;
        logic [SlotW-1:0]        slot;
        logic [CountW-1:0]       used;
        logic                    found;
        logic [SlotW-1:0]        best_idx;
        logic [DistW-1:0]        best_dist;
        // absorb results carried back to the target cell
        logic                    wr;
        feat_t [Features-1:0]    wr_center;
    } beat_t;

    typedef struct packed {
        logic [Features-1:0][15:0] box;
        logic [DateW-1:0]          thr;
        logic [8:0]                pen;
    } cfg_t;
endpackage
`default_nettype wire

FILE: design/hmt_div.sv
// Restoring divider for the absorb running mean: signed numerator by n+1,
// rounded to nearest with ties away from zero. Uses hmt_pkg.
`default_nettype none
module hmt_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic signed [33:0]           num,
    input  wire logic [16:0]                  den,
    output logic                              done,
    output hmt_pkg::feat_t                    quot
);
    localparam int MagW = 34;
    logic [MagW-1:0] rem_reg, rem_next, q_reg, q_next;
    logic [16:0]     den_reg;
    logic            neg_reg;
    logic [5:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [MagW:0]   trial;
    logic [MagW-1:0] mag;
    logic [MagW-1:0] q_signed;

    assign mag = num[33] ? MagW'(-num) : MagW'(num);

    // one quotient bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = '0;
        if (start) begin
            rem_next  = '0;
            q_next    = mag + MagW'(den >> 1);
            cnt_next  = 6'(MagW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {rem_reg, q_reg[MagW-1]} - {18'd0, den_reg};
            if (!trial[MagW]) begin
                rem_next = trial[MagW-1:0];
                q_next   = {q_reg[MagW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[MagW-2:0], q_reg[MagW-1]};
                q_next   = {q_reg[MagW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start) begin
            den_reg <= den;
            neg_reg <= num[33];
        end
    end

    // last quotient bit is formed in the done cycle
    assign q_signed = neg_reg ? -q_next : q_next;
    assign quot     = hmt_pkg::feat_t'(q_signed[15:0]);
    assign done     = busy_reg && (cnt_reg == 6'd1);
endmodule
`default_nettype wire

FILE: design/hmt_cell.sv
// One table entry: center, count and date, with the search, add, absorb-write
// and age logic applied to the beat passing through. Uses hmt_pkg.
`default_nettype none
module hmt_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [hmt_pkg::SlotW-1:0]   my_idx,
    input  wire hmt_pkg::cfg_t               cfg,
    input  wire hmt_pkg::beat_t              beat_in,
    output hmt_pkg::beat_t                   beat_out,
    output logic [hmt_pkg::NCntW-1:0]        count_out,
    output hmt_pkg::feat_t [hmt_pkg::Features-1:0] center_out
);
    hmt_pkg::feat_t [hmt_pkg::Features-1:0] center_reg;
    logic [hmt_pkg::NCntW-1:0] count_reg;
    logic [hmt_pkg::DateW-1:0] date_reg;
    hmt_pkg::beat_t            beat_reg, beat_next;
    logic                      occupied;
    logic                      hit;
    logic                      inbox;
    logic [hmt_pkg::DistW-1:0] sum;
    logic [16:0]               d [hmt_pkg::Features];
    logic [32:0]               limit;
    logic [24:0]               prod;
    logic [hmt_pkg::NCntW-1:0] aged;

    assign occupied = {1'b0, my_idx} < beat_in.used;
    assign hit      = beat_in.valid && (beat_in.slot == my_idx);

    // distance and box test for this entry
    always_comb begin
        inbox = 1'b1;
        sum   = '0;
        for (int f = 0; f < hmt_pkg::Features; f++) begin
            d[f] = (center_reg[f] > beat_in.feat[f])
                 ? 17'({center_reg[f][15], center_reg[f]} - {beat_in.feat[f][15], beat_in.feat[f]})
                 : 17'({beat_in.feat[f][15], beat_in.feat[f]} - {center_reg[f][15], center_reg[f]});
            if ({d[f], 1'b0} >= {2'b00, cfg.box[f]}) inbox = 1'b0;
            sum = sum + hmt_pkg::DistW'(d[f]);
        end
    end

    assign limit = {1'b0, date_reg} + {1'b0, cfg.thr};
    assign prod  = 25'(count_reg) * 25'(cfg.pen);
    always_comb begin
        if (prod[24:8] == '0)          aged = 16'd1;
        else if (prod[24] != 1'b0)     aged = 16'hFFFF;
        else                           aged = prod[23:8];
    end

    always_comb begin
        beat_next = beat_in;
        if (beat_in.valid && occupied && beat_in.kind == hmt_pkg::KIND_SEARCH && inbox &&
            (!beat_in.found || sum < beat_in.best_dist)) begin
            beat_next.found     = 1'b1;
            beat_next.best_idx  = my_idx;
            beat_next.best_dist = sum;
        end
    end

    // entry update
    always_ff @(posedge aclk) begin
        if (beat_in.valid && beat_in.kind == hmt_pkg::KIND_ADD && !beat_in.wr &&
            {1'b0, my_idx} == beat_in.used) begin
            center_reg <= beat_in.feat;
            count_reg  <= 16'd1;
            date_reg   <= beat_in.date;
        end
        if (hit && beat_in.kind == hmt_pkg::KIND_ABSORB && beat_in.wr) begin
            center_reg <= beat_in.wr_center;
            if (count_reg != 16'hFFFF) count_reg <= count_reg + 16'd1;
            if (beat_in.date > date_reg) date_reg <= beat_in.date;
        end
        if (beat_in.valid && occupied && beat_in.kind == hmt_pkg::KIND_AGE &&
            limit < {1'b0, beat_in.date} && count_reg > 16'd1) begin
            count_reg <= aged;
        end
        if (!aresetn) beat_reg <= '0;
        else          beat_reg <= beat_next;
    end

    assign beat_out   = beat_reg;
    assign count_out  = count_reg;
    assign center_out = center_reg;
endmodule
`default_nettype wire

FILE: design/hyperbox_microcluster_table_top.sv
// Top level of the hyperbox micro-cluster table: configuration registers,
// item sequencer, chain of hmt_cell entries and the hmt_div mean divider.
// Depends on hmt_pkg, hmt_cell and hmt_div.
//
// One item at a time. A search, add or age item walks the chain of 16 cells,
// one cell per cycle, and its result is registered once the beat leaves the
// last cell. An absorb item to an occupied slot first runs one divider pass
// per feature (each forming 34 quotient bits) to form the running mean, then
// walks the chain to write it. The result sits in an output register; the
// next item is taken once it is delivered. No clearing pass after reset.
`default_nettype none
module hyperbox_microcluster_table_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [15:0] s_feature_0,
    input  wire logic [15:0] s_feature_1,
    input  wire logic [15:0] s_feature_2,
    input  wire logic [15:0] s_feature_3,
    input  wire logic [31:0] s_sample_date,
    input  wire logic [3:0]  s_target_slot,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_match_found,
    output logic [3:0]       m_match_index,
    output logic [17:0]      m_match_distance,
    output logic [1:0]       m_status,
    output logic [4:0]       m_cluster_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int N = hmt_pkg::MaxClusters;
    localparam int F = hmt_pkg::Features;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_WALK = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t         state_reg;
    hmt_pkg::cfg_t  cfg_reg;
    logic [hmt_pkg::CountW-1:0] used_reg;
    hmt_pkg::beat_t item_reg;
    hmt_pkg::beat_t head_beat;
    hmt_pkg::beat_t chain [N+1];
    logic [hmt_pkg::NCntW-1:0] cnt_w [N];
    hmt_pkg::feat_t [F-1:0] ctr_w [N];
    logic [1:0]     fidx_reg;
    logic           div_start_reg, div_start_next, div_done;
    hmt_pkg::feat_t div_q;
    logic [hmt_pkg::NCntW-1:0] n_sel;
    hmt_pkg::feat_t c_sel;
    logic signed [33:0] div_num;
    logic           absorb_ok;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.box <= {4{16'd4096}};
            cfg_reg.thr <= 32'd1000;
            cfg_reg.pen <= 9'd128;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hmt_pkg::REG_BOX0:    cfg_reg.box[0] <= cfg_data[15:0];
                hmt_pkg::REG_BOX1:    cfg_reg.box[1] <= cfg_data[15:0];
                hmt_pkg::REG_BOX2:    cfg_reg.box[2] <= cfg_data[15:0];
                hmt_pkg::REG_BOX3:    cfg_reg.box[3] <= cfg_data[15:0];
                hmt_pkg::REG_AGE_THR: cfg_reg.thr    <= cfg_data;
                hmt_pkg::REG_AGE_PEN: cfg_reg.pen    <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign absorb_ok = {1'b0, item_reg.slot} < used_reg;
    assign n_sel     = cnt_w[item_reg.slot];
    assign c_sel     = ctr_w[item_reg.slot][fidx_reg];
    assign div_num   = 34'(item_reg.feat[fidx_reg]) + $signed({1'b0, n_sel}) * c_sel;

    // divider start: on absorb acceptance and after each feature but the last
    always_comb begin
        div_start_next = 1'b0;
        if (state_reg == S_IDLE && s_valid && s_kind == hmt_pkg::KIND_ABSORB)
            div_start_next = 1'b1;
        if (state_reg == S_DIV && absorb_ok && div_done && fidx_reg != 2'(F-1))
            div_start_next = 1'b1;
    end

    hmt_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .num(div_num), .den({1'b0, n_sel} + 17'd1), .done(div_done), .quot(div_q)
    );

    // chain of entries
    always_comb begin
        head_beat       = item_reg;
        head_beat.valid = (state_reg == S_WALK) && !item_reg.found;
    end
    assign chain[0] = head_beat;
    for (genvar i = 0; i < N; i++) begin : g_cell
        hmt_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .my_idx(hmt_pkg::SlotW'(i)), .cfg(cfg_reg),
            .beat_in(chain[i]), .beat_out(chain[i+1]),
            .count_out(cnt_w[i]), .center_out(ctr_w[i])
        );
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= div_start_next;
            unique case (state_reg)
                S_IDLE: if (s_valid) begin
                    item_reg.valid     <= 1'b1;
                    item_reg.kind      <= s_kind;
                    item_reg.feat      <= {s_feature_3, s_feature_2, s_feature_1, s_feature_0};
                    item_reg.date      <= s_sample_date;
                    item_reg.slot      <= s_target_slot;
                    item_reg.used      <= used_reg;
                    item_reg.found     <= 1'b0;
                    item_reg.best_idx  <= '0;
                    item_reg.best_dist <= '0;
                    item_reg.wr        <= 1'b0;
                    fidx_reg           <= '0;
                    if (s_kind == hmt_pkg::KIND_ABSORB) state_reg <= S_DIV;
                    else state_reg <= S_WALK;
                end
                S_DIV: begin
                    if (!absorb_ok) state_reg <= S_WALK;
                    else if (div_done) begin
                        item_reg.wr_center[fidx_reg] <= div_q;
                        if (fidx_reg == 2'(F-1)) begin
                            item_reg.wr <= 1'b1;
                            state_reg <= S_WALK;
                        end else begin
                            fidx_reg <= fidx_reg + 2'd1;
                        end
                    end
                end
                S_WALK: begin
                    // found marks that the beat has left the chain head
                    item_reg.found <= 1'b1;
                    if (chain[N].valid) begin
                        state_reg <= S_OUT;
                        m_match_found    <= 1'b0;
                        m_match_index    <= '0;
                        m_match_distance <= '0;
                        m_status         <= hmt_pkg::ST_OK;
                        m_cluster_count  <= used_reg;
                        unique case (chain[N].kind)
                            hmt_pkg::KIND_SEARCH: begin
                                m_match_found    <= chain[N].found;
                                m_match_index    <= chain[N].found ? chain[N].best_idx : '0;
                                m_match_distance <= chain[N].found ? chain[N].best_dist : '0;
                            end
                            hmt_pkg::KIND_ADD: begin
                                if (used_reg >= hmt_pkg::CountW'(N)) m_status <= hmt_pkg::ST_FULL;
                                else begin
                                    m_match_index   <= used_reg[hmt_pkg::SlotW-1:0];
                                    used_reg        <= used_reg + 5'd1;
                                    m_cluster_count <= used_reg + 5'd1;
                                end
                            end
                            hmt_pkg::KIND_ABSORB: begin
                                m_match_index <= chain[N].slot;
                                if (!chain[N].wr) m_status <= hmt_pkg::ST_EMPTY;
                            end
                            default: ;
                        endcase
                    end
                end
                S_OUT: if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/hmt_checker.sv
// Port-level checker for the micro-cluster table, bound to the top level.
// Depends on hyperbox_microcluster_table_top's ports and hmt_pkg.
`default_nettype none
module hmt_port_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_match_found,
    input wire logic [17:0] m_match_distance,
    input wire logic [1:0]  m_status,
    input wire logic [4:0]  m_cluster_count
);
    // a stalled result stays valid with its cluster count held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cluster_count))
        else $error("result changed while stalled");
    // a waiting input beat stays offered
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input valid dropped before acceptance");
    // one item in flight: no input taken while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken with result pending");
    // no distance without a match
    a_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_match_found |-> m_match_distance == 18'd0)
        else $error("distance without match");
    // count within table size and status code legal
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cluster_count <= 5'd16 && m_status != hmt_pkg::ST_UNUSED)
        else $error("bad count or status");
endmodule

bind hyperbox_microcluster_table_top hmt_port_checker u_hmt_checker (.*);
`default_nettype wire
